// ===== sv/lkvc_pkg.sv =====
// ----------------------------------------------------------------------------
// lkvc_pkg
// Shared constants, request codes and control structs for the LRU cache.
// ----------------------------------------------------------------------------
package lkvc_pkg;

  localparam int ENTRIES   = 16;                       // built depth
  localparam int IDX_W     = $clog2(ENTRIES);          // slot index / rank width
  localparam int CAP_W     = $clog2(ENTRIES + 1);      // holds 0..ENTRIES
  localparam int KEY_W     = 31;
  localparam int VAL_W     = 32;
  localparam int CFG_W     = 5;
  localparam int CAP_RESET = (16 > ENTRIES) ? ENTRIES : 16;

  localparam logic REQ_ADD    = 1'b0;
  localparam logic REQ_ACCESS = 1'b1;

  // controller -> datapath
  typedef struct packed {
    logic load;     // capture the incoming request
    logic commit;   // apply the held request, load result if an access
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic res_blocked;  // access held back: result register still occupied
  } status_t;

endpackage

// ===== sv/lkvc_ctrl.sv =====
// ----------------------------------------------------------------------------
// lkvc_ctrl
// Two-state sequencer: take a request, then execute it once the result side
// has room.
// ----------------------------------------------------------------------------
module lkvc_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             req_valid,
  input  lkvc_pkg::status_t st,
  output logic             req_stall,
  output lkvc_pkg::cmd_t    cmd
);

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_t;

  state_t state;

  always_comb begin
    cmd.load   = (state == S_IDLE) && req_valid;
    cmd.commit = (state == S_EXEC) && !st.res_blocked;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      req_stall <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (req_valid) begin
            state     <= S_EXEC;
            req_stall <= 1'b1;
          end
        end
        S_EXEC: begin
          if (!st.res_blocked) begin
            state     <= S_IDLE;
            req_stall <= 1'b0;
          end
        end
      endcase
    end
  end

`ifndef SYNTH
  a_load_then_exec: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> (cmd.commit || st.res_blocked))
    else $error("request taken but not executed next cycle");

  a_commit_frees: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |=> !req_stall)
    else $error("request side still stalled after commit");

  a_stall_in_exec: assert property (@(posedge clk) disable iff (rst)
    req_stall == (state == S_EXEC))
    else $error("request stall out of step with state");
`endif

endmodule

// ===== sv/lkvc_datapath.sv =====
// ----------------------------------------------------------------------------
// lkvc_datapath
// Entry store, parallel key match, victim pick, recency ranks and result
// register.
// ----------------------------------------------------------------------------
module lkvc_datapath (
  input  logic                           clk,
  input  logic                           rst,
  input  lkvc_pkg::cmd_t                 cmd,
  output lkvc_pkg::status_t              st,
  input  logic                           cfg_we,
  input  logic [lkvc_pkg::CFG_W-1:0]     cfg_wdata,
  input  logic                           req_type,
  input  logic [lkvc_pkg::KEY_W-1:0]     key,
  input  logic signed [lkvc_pkg::VAL_W-1:0] value,
  output logic                           res_valid,
  input  logic                           res_stall,
  output logic                           hit,
  output logic signed [lkvc_pkg::VAL_W-1:0] read_value
);

  localparam int N  = lkvc_pkg::ENTRIES;
  localparam int IW = lkvc_pkg::IDX_W;
  localparam int CW = lkvc_pkg::CAP_W;

  // entry store
  logic [N-1:0]                  valid;
  logic [lkvc_pkg::KEY_W-1:0]    keys   [N];
  logic [lkvc_pkg::VAL_W-1:0]    vals   [N];
  logic [IW-1:0]                 rank   [N];
  logic [CW-1:0]                 fill_count;
  logic [CW-1:0]                 cap;

  // held request
  logic                          req_type_q;
  logic [lkvc_pkg::KEY_W-1:0]    key_q;
  logic [lkvc_pkg::VAL_W-1:0]    value_q;

  // decode
  logic [CW-1:0]  cap_wr;
  logic [N-1:0]   elig;
  logic [N-1:0]   match;
  logic [N-1:0]   victim_oh;
  logic           found;
  logic           have;
  logic           full;
  logic           is_add;
  logic           do_insert;
  logic           do_replace;
  logic           do_touch;
  logic [IW-1:0]  f_idx;
  logic [IW-1:0]  vic_idx;
  logic [IW-1:0]  fill_idx;
  logic [IW-1:0]  tgt;
  logic [IW-1:0]  tgt_rank;

  // capacity saturates on write: 0 acts as 1, above depth acts as depth
  always_comb begin
    if (cfg_wdata == '0)
      cap_wr = CW'(1);
    else if (32'(cfg_wdata) > 32'(N))
      cap_wr = CW'(N);
    else
      cap_wr = CW'(cfg_wdata);
  end

  always_comb begin
    for (int i = 0; i < N; i++) begin
      elig[i]  = valid[i] && (CW'(i) < cap);
      match[i] = elig[i] && (keys[i] == key_q);
    end
  end

  // lowest matching slot wins
  always_comb begin
    f_idx = '0;
    for (int i = N - 1; i >= 0; i--) begin
      if (match[i]) f_idx = IW'(i);
    end
  end

  // victim: eligible slot whose rank beats every other eligible slot
  always_comb begin
    for (int i = 0; i < N; i++) begin
      victim_oh[i] = elig[i];
      for (int j = 0; j < N; j++) begin
        if (j != i && elig[j] && !(rank[i] > rank[j])) victim_oh[i] = 1'b0;
      end
    end
  end

  always_comb begin
    vic_idx = '0;
    for (int i = 0; i < N; i++) begin
      if (victim_oh[i]) vic_idx = vic_idx | IW'(i);
    end
  end

  always_comb begin
    found      = |match;
    have       = |victim_oh;
    full       = !(fill_count < cap);
    is_add     = (req_type_q == lkvc_pkg::REQ_ADD);
    fill_idx   = fill_count[IW-1:0];
    do_insert  = is_add && !found && !full;
    do_replace = is_add && !found && full && have;
    do_touch   = found || do_replace;
    tgt        = found ? f_idx : vic_idx;
    tgt_rank   = rank[tgt];
    st.res_blocked = !is_add && res_valid && res_stall;
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      valid      <= '0;
      fill_count <= '0;
      cap        <= CW'(lkvc_pkg::CAP_RESET);
      res_valid  <= 1'b0;
    end else begin
      if (cfg_we) cap <= cap_wr;
      // a new access result replaces one taken at this same edge
      if (cmd.commit && !is_add) begin
        res_valid <= 1'b1;
      end else if (!res_stall) begin
        res_valid <= 1'b0;
      end
      if (cmd.commit && do_insert) begin
        valid[fill_idx] <= 1'b1;
        fill_count      <= fill_count + CW'(1);
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_type_q <= req_type;
      key_q      <= key;
      value_q    <= value;
    end
    if (cmd.commit) begin
      if (do_insert) begin
        keys[fill_idx] <= key_q;
        vals[fill_idx] <= value_q;
        for (int i = 0; i < N; i++) begin
          if (valid[i]) rank[i] <= rank[i] + IW'(1);
        end
        rank[fill_idx] <= '0;
      end
      if (do_touch) begin
        if (is_add) vals[tgt] <= value_q;
        if (do_replace) keys[tgt] <= key_q;
        for (int i = 0; i < N; i++) begin
          if (valid[i] && IW'(i) != tgt && rank[i] < tgt_rank)
            rank[i] <= rank[i] + IW'(1);
        end
        rank[tgt] <= '0;
      end
      if (!is_add) begin
        hit        <= found;
        read_value <= found ? vals[f_idx] : '1;
      end
    end
  end

`ifndef SYNTH
  a_victim_unique: assert property (@(posedge clk) disable iff (rst)
    $onehot0(victim_oh))
    else $error("recency ranks of eligible slots collide");

  a_insert_free_slot: assert property (@(posedge clk) disable iff (rst)
    (cmd.commit && do_insert) |-> !valid[fill_idx])
    else $error("fill slot already in use");

  a_add_no_result: assert property (@(posedge clk) disable iff (rst)
    (cmd.commit && is_add && !res_valid) |=> !res_valid)
    else $error("add request produced a result");
`endif

endmodule

// ===== sv/lru_key_value_cache.sv =====
// ----------------------------------------------------------------------------
// lru_key_value_cache
// Fully associative key/value cache with least-recently-used replacement.
// ----------------------------------------------------------------------------
// Flow: a new request is taken only once the last has executed (take, then
//   execute against the entry registers: one parallel key compare and rank
//   update per request). An access result is registered when it executes.
// An access waits in execute while the previous result is still stalled.
// Reset (synchronous, rst high): all entries invalid, fill count zero,
//   capacity at its full value; no clearing pass, ready at once.
// ----------------------------------------------------------------------------
module lru_key_value_cache (
  input  logic                              clk,
  input  logic                              rst,
  // configuration: capacity register
  input  logic                              cfg_we,
  input  logic [lkvc_pkg::CFG_W-1:0]        cfg_wdata,
  // request channel
  input  logic                              req_valid,
  output logic                              req_stall,
  input  logic                              req_type,
  input  logic [lkvc_pkg::KEY_W-1:0]        key,
  input  logic signed [lkvc_pkg::VAL_W-1:0] value,
  // result channel
  output logic                              res_valid,
  input  logic                              res_stall,
  output logic                              hit,
  output logic signed [lkvc_pkg::VAL_W-1:0] read_value
);

  lkvc_pkg::cmd_t    cmd;
  lkvc_pkg::status_t st;

  // Sequencer: idle -> execute -> idle. The request is captured on the
  // idle cycle, and applied on the execute cycle unless an access result
  // would overwrite one still waiting at the output.
  lkvc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .st        (st),
    .req_stall (req_stall),
    .cmd       (cmd)
  );

  // Datapath: entry registers with a compare per slot, victim pick from
  // pairwise rank compares, rank aging, and the result register that
  // decouples the result side from the request side.
  // Adds never produce a result; a miss returns hit low and all ones.
  lkvc_datapath u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .st         (st),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .req_type   (req_type),
    .key        (key),
    .value      (value),
    .res_valid  (res_valid),
    .res_stall  (res_stall),
    .hit        (hit),
    .read_value (read_value)
  );

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the LRU key/value cache. A shadow copy of the
// entry store predicts every access result; a monitor compares each result
// taken from the block against the oldest prediction. Directed requests
// cover the field extremes, eviction and the capacity corner cases, then
// phased random traffic runs at several capacities with random idling, and a last stretch runs without idling.
// ----------------------------------------------------------------------------
module tb_top;

  typedef struct packed {
    logic                       hit;
    logic [lkvc_pkg::VAL_W-1:0] read_value;
  } read_result_t;

  // --------------------------------------------------------------------------
  // Clock, reset and block inputs, all known from time zero
  // --------------------------------------------------------------------------
  logic                               clk        = 1'b0;
  logic                               rst        = 1'b1;
  logic                               cfg_we     = 1'b0;
  logic [lkvc_pkg::CFG_W-1:0]         cfg_wdata  = '0;
  logic                               req_valid  = 1'b0;
  logic                               req_type   = lkvc_pkg::REQ_ADD;
  logic [lkvc_pkg::KEY_W-1:0]         key        = '0;
  logic signed [lkvc_pkg::VAL_W-1:0]  value      = '0;
  logic                               res_stall  = 1'b0;
  logic                               req_stall;
  logic                               res_valid;
  logic                               hit;
  logic signed [lkvc_pkg::VAL_W-1:0]  read_value;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  lru_key_value_cache dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .req_valid  (req_valid),
    .req_stall  (req_stall),
    .req_type   (req_type),
    .key        (key),
    .value      (value),
    .res_valid  (res_valid),
    .res_stall  (res_stall),
    .hit        (hit),
    .read_value (read_value)
  );

  // --------------------------------------------------------------------------
  // Shadow store: mirrors entry state so each access can be predicted
  // --------------------------------------------------------------------------
  logic                       shadow_valid [lkvc_pkg::ENTRIES];
  logic [lkvc_pkg::KEY_W-1:0] shadow_key   [lkvc_pkg::ENTRIES];
  logic [lkvc_pkg::VAL_W-1:0] shadow_val   [lkvc_pkg::ENTRIES];
  logic [lkvc_pkg::IDX_W-1:0] shadow_rank  [lkvc_pkg::ENTRIES];  // 0 = most recent
  logic [lkvc_pkg::CAP_W-1:0] shadow_fill;                       // filled from 0 up
  logic [lkvc_pkg::CFG_W-1:0] shadow_cap = lkvc_pkg::CFG_W'(lkvc_pkg::CAP_RESET);

  read_result_t               pending_reads [$];  // predicted access results, oldest first
  int                         fail_count = 0;
  bit                         idling_on  = 1'b1;  // random gaps and stalls allowed
  int                         stall_left = 0;
  logic [lkvc_pkg::KEY_W-1:0] key_pool [24];
  read_result_t               head_result;

  initial begin
    for (int i = 0; i < lkvc_pkg::ENTRIES; i++) shadow_valid[i] = 1'b0;
    shadow_fill = '0;
  end

  // register value 0 behaves as 1, anything above the built depth as the depth
  function automatic int slots_in_use();
    if (shadow_cap == 0) return 1;
    if (shadow_cap > lkvc_pkg::ENTRIES) return lkvc_pkg::ENTRIES;
    return int'(shadow_cap);
  endfunction

  // lowest matching slot wins when duplicates exist
  function automatic int find_slot(input logic [lkvc_pkg::KEY_W-1:0] k, input int span);
    for (int i = 0; i < span; i++)
      if (shadow_valid[i] && shadow_key[i] == k) return i;
    return -1;
  endfunction

  task automatic promote_slot(input int s);
    logic [lkvc_pkg::IDX_W-1:0] r;
    r = shadow_rank[s];
    for (int i = 0; i < lkvc_pkg::ENTRIES; i++)
      if (shadow_valid[i] && i != s && shadow_rank[i] < r) shadow_rank[i]++;
    shadow_rank[s] = '0;
  endtask

  task automatic occupy_slot(input int s);
    for (int i = 0; i < lkvc_pkg::ENTRIES; i++)
      if (shadow_valid[i]) shadow_rank[i]++;
    shadow_valid[s] = 1'b1;
    shadow_rank[s]  = '0;
  endtask

  // Apply one accepted request to the shadow store; queue a result for access.
  task automatic predict_request(input logic t, input logic [lkvc_pkg::KEY_W-1:0] k,
                                 input logic [lkvc_pkg::VAL_W-1:0] v);
    int           span;
    int           slot;
    int           victim;
    read_result_t r;
    span = slots_in_use();
    slot = find_slot(k, span);
    if (t == lkvc_pkg::REQ_ADD) begin
      if (slot >= 0) begin
        shadow_val[slot] = v;
        promote_slot(slot);
      end else if (int'(shadow_fill) < span) begin
        slot = int'(shadow_fill);
        shadow_key[slot] = k;
        shadow_val[slot] = v;
        occupy_slot(slot);
        shadow_fill++;
      end else begin
        // full: evict the visible valid slot with the greatest rank
        victim = -1;
        for (int i = 0; i < span; i++)
          if (shadow_valid[i] && (victim < 0 || shadow_rank[i] > shadow_rank[victim]))
            victim = i;
        if (victim >= 0) begin
          shadow_key[victim] = k;
          shadow_val[victim] = v;
          promote_slot(victim);
        end
      end
    end else begin
      if (slot >= 0) begin
        promote_slot(slot);
        r.hit        = 1'b1;
        r.read_value = shadow_val[slot];
      end else begin
        r.hit        = 1'b0;
        r.read_value = '1;
      end
      pending_reads.push_back(r);
    end
  endtask

  // --------------------------------------------------------------------------
  // Result side: random stall bursts, and the checker
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst || !idling_on) begin
      stall_left = 0;
      res_stall <= 1'b0;
    end else begin
      if (stall_left == 0 && $urandom_range(0, 7) == 0) stall_left = $urandom_range(1, 14);
      if (stall_left != 0) begin
        res_stall <= 1'b1;
        stall_left--;
      end else begin
        res_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && res_valid && !res_stall) begin
      if (pending_reads.size() == 0) begin
        $error("unexpected result: hit %0b, read_value %h", hit, read_value);
        fail_count++;
      end else begin
        head_result = pending_reads.pop_front();
        if (hit !== head_result.hit) begin
          $error("hit: expected %0b, actual %0b", head_result.hit, hit);
          fail_count++;
        end
        if (read_value !== head_result.read_value) begin
          $error("read_value: expected %h, actual %h", head_result.read_value, read_value);
          fail_count++;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Request side
  // --------------------------------------------------------------------------
  // Drive one request and hold it until taken. This task lowers valid only on a
  // gap, so back-to-back requests keep it high without a second assignment.
  task automatic send_request(input logic t, input logic [lkvc_pkg::KEY_W-1:0] k,
                              input logic [lkvc_pkg::VAL_W-1:0] v);
    int gap;
    if (idling_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 14);
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_valid <= 1'b1;
    req_type  <= t;
    key       <= k;
    value     <= v;
    do @(posedge clk); while (req_stall);
    predict_request(t, k, v);
  endtask

  // Stop sending and let every outstanding result drain. Adds give no
  // result, so also wait for one that may still be in execute.
  task automatic drain_results();
    req_valid <= 1'b0;
    while (pending_reads.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_capacity(input logic [lkvc_pkg::CFG_W-1:0] c);
    drain_results();
    cfg_we    <= 1'b1;
    cfg_wdata <= c;
    @(posedge clk);
    cfg_we    <= 1'b0;
    shadow_cap = c;
  endtask

  function automatic logic [lkvc_pkg::KEY_W-1:0] pick_key();
    int sel;
    int span;
    sel  = $urandom_range(0, 9);
    span = slots_in_use() + 3;
    if (span > 23) span = 23;
    if (sel < 7) return key_pool[$urandom_range(0, span)];
    if (sel == 7) return ($urandom_range(0, 1) != 0) ? '1 : '0;
    return lkvc_pkg::KEY_W'($urandom);
  endfunction

  function automatic logic [lkvc_pkg::VAL_W-1:0] pick_value();
    case ($urandom_range(0, 7))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return '1;
      default: return $urandom;
    endcase
  endfunction

  task automatic send_random_request();
    logic t;
    t = ($urandom_range(0, 1) != 0) ? lkvc_pkg::REQ_ACCESS : lkvc_pkg::REQ_ADD;
    send_request(t, pick_key(), pick_value());
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  // Field extremes at full capacity: keys 0 and all ones, values at both ends,
  // a miss on the empty cache, an update in place, a stored -1 against a miss.
  task automatic test_field_extremes();
    send_request(lkvc_pkg::REQ_ACCESS, '0, $urandom);
    send_request(lkvc_pkg::REQ_ADD, '0, 32'h7FFF_FFFF);
    send_request(lkvc_pkg::REQ_ADD, '1, 32'h8000_0000);
    send_request(lkvc_pkg::REQ_ACCESS, '0, '1);
    send_request(lkvc_pkg::REQ_ACCESS, '1, '0);
    send_request(lkvc_pkg::REQ_ACCESS, 31'd12345, $urandom);
    send_request(lkvc_pkg::REQ_ADD, '0, '1);
    send_request(lkvc_pkg::REQ_ACCESS, '0, $urandom);
  endtask

  // Capacity 3: third add fills slot 2, then a fourth evicts the LRU entry.
  // Key 100 is touched first so it survives in slot 2.
  task automatic test_lru_eviction();
    write_capacity(5'd3);
    send_request(lkvc_pkg::REQ_ADD, 31'd100, 32'd1000);
    send_request(lkvc_pkg::REQ_ACCESS, 31'd100, '0);
    send_request(lkvc_pkg::REQ_ADD, 31'd200, 32'd2000);
    send_request(lkvc_pkg::REQ_ACCESS, '0, '0);
    send_request(lkvc_pkg::REQ_ACCESS, '1, '0);
    send_request(lkvc_pkg::REQ_ACCESS, 31'd200, '0);
  endtask

  // Register 0 acts as one slot, hidden slots stay intact, 31 saturates to the
  // full depth; key 100 then lives in slots 0 and 2 and slot 0 must win.
  task automatic test_capacity_limits();
    write_capacity(5'd0);
    send_request(lkvc_pkg::REQ_ADD, 31'd100, 32'hDEAD_BEEF);
    send_request(lkvc_pkg::REQ_ACCESS, 31'd100, '0);
    send_request(lkvc_pkg::REQ_ACCESS, 31'd200, '0);
    write_capacity(5'd31);
    send_request(lkvc_pkg::REQ_ACCESS, 31'd100, '0);
    send_request(lkvc_pkg::REQ_ADD, 31'd300, 32'd3);
    send_request(lkvc_pkg::REQ_ACCESS, 31'd300, '0);
    send_request(lkvc_pkg::REQ_ACCESS, 31'd200, '0);
  endtask

  // Phases at a spread of capacities over a shared key pool, so that hits,
  // refills, evictions and duplicates all come up. Each phase drains at its start and once part way through.
  task automatic test_random_traffic();
    logic [lkvc_pkg::CFG_W-1:0] plan [8] = '{5'd16, 5'd1, 5'd5, 5'd2,
                                             5'd31, 5'd0, 5'd9, 5'd16};
    logic [lkvc_pkg::CFG_W-1:0] c;
    int                         pause_at;
    for (int i = 0; i < 24; i++) key_pool[i] = lkvc_pkg::KEY_W'($urandom);
    for (int p = 0; p < 10; p++) begin
      c = (p < 8) ? plan[p] : lkvc_pkg::CFG_W'($urandom_range(0, 31));
      write_capacity(c);
      pause_at = $urandom_range(5, 40);
      for (int i = 0; i < 45; i++) begin
        if (i == pause_at) drain_results();
        send_random_request();
      end
    end
  endtask

  // Final stretch at full rate on both sides.
  task automatic test_back_to_back();
    drain_results();
    idling_on = 1'b0;
    for (int i = 0; i < 50; i++) send_random_request();
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_field_extremes();
    test_lru_eviction();
    test_capacity_limits();
    test_random_traffic();
    test_back_to_back();
    drain_results();
    repeat (10) @(posedge clk);
    if (fail_count == 0 && pending_reads.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #2_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
